FILE: rtl/core/ffua_pkg.sv
package ffua_pkg;

  localparam int MAX_UNITS = 256;
  localparam int ID_BITS   = 8;

  localparam int UNIT_W   = $clog2(MAX_UNITS);
  localparam int CNT_W    = $clog2(MAX_UNITS + 1);
  localparam int KIND_W   = 1;
  localparam int SIZE_W   = 9;
  localparam int STATUS_W = 2;
  localparam int START_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int CFG_W    = 9;

  localparam logic [CFG_W-1:0] MEM_UNITS_RESET = CFG_W'(256);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_NO_HOLE = 2'd1,
    STATUS_BAD     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_FREE,
    ST_STATS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic empty;
  } stats_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] largest;
    logic [CNT_W-1:0] smallest;
  } stats_t;

endpackage

FILE: rtl/core/ffua_ram.sv
module ffua_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/ffua_hole_stats.sv
module ffua_hole_stats (
  input  logic                 clk,
  input  ffua_pkg::stats_ctrl_t ctrl,
  output ffua_pkg::stats_t      stats
);

  logic [ffua_pkg::CNT_W-1:0] run;
  logic [ffua_pkg::CNT_W-1:0] big;
  logic [ffua_pkg::CNT_W-1:0] small_len;
  logic [ffua_pkg::CNT_W-1:0] cnt;
  logic [ffua_pkg::CNT_W-1:0] big_next;
  logic [ffua_pkg::CNT_W-1:0] small_next;

  always_comb begin
    big_next   = (run > big) ? run : big;
    small_next = small_len;
    if (run != '0 && (small_len == '0 || run < small_len)) begin
      small_next = run;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      run       <= '0;
      big       <= '0;
      small_len <= '0;
      cnt       <= '0;
    end else if (ctrl.step) begin
      if (ctrl.empty) begin
        run <= run + ffua_pkg::CNT_W'(1);
      end else begin
        cnt       <= cnt + ffua_pkg::CNT_W'(1);
        big       <= big_next;
        small_len <= small_next;
        run       <= '0;
      end
    end
  end

  assign stats.used     = cnt;
  assign stats.largest  = big_next;
  assign stats.smallest = small_next;

endmodule

FILE: rtl/core/first_fit_unit_allocator.sv
// After reset the unit store is cleared one unit a cycle, all MAX_UNITS units,
// with no transfer accepted; the size register and out_valid reset at once.
// An allocate runs a first-fit scan and a hole scan over n_units units and a fill of
// request_size units, plus a step to accept and one to load the result; a free runs a
// release scan of all MAX_UNITS units in place of scan and fill. One item is in work at
// a time, bounded by the single read port; a held result stalls FINISH.
module first_fit_unit_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ffua_pkg::KIND_W-1:0]     kind,
  input  logic [ffua_pkg::ID_BITS-1:0]    owner_id,
  input  logic [ffua_pkg::SIZE_W-1:0]     request_size,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ffua_pkg::STATUS_W-1:0]   status,
  output logic [ffua_pkg::START_W-1:0]    start_unit,
  output logic [ffua_pkg::COUNT_W-1:0]    used_units,
  output logic [ffua_pkg::COUNT_W-1:0]    largest_hole,
  output logic [ffua_pkg::COUNT_W-1:0]    smallest_hole,
  input  logic                            cfg_wr_en,
  input  logic [ffua_pkg::CFG_W-1:0]      cfg_wr_data
);

  localparam logic [ffua_pkg::CNT_W-1:0] MAX_CNT = ffua_pkg::CNT_W'(ffua_pkg::MAX_UNITS);

  ffua_pkg::state_t state, state_next;

  logic [ffua_pkg::CFG_W-1:0]   mem_units;
  logic [ffua_pkg::CNT_W-1:0]   n_units;
  logic [ffua_pkg::CNT_W-1:0]   addr;
  logic                         pend;
  logic [ffua_pkg::UNIT_W-1:0]  pend_addr;
  logic [ffua_pkg::CNT_W-1:0]   run;
  logic [ffua_pkg::CNT_W-1:0]   fill_cnt;
  logic [ffua_pkg::UNIT_W-1:0]  start;
  logic [ffua_pkg::ID_BITS-1:0] req_id;
  logic [ffua_pkg::CNT_W-1:0]   req_size;
  ffua_pkg::status_t            status_q;

  logic [ffua_pkg::CNT_W-1:0]   in_size;
  logic                         in_bad;
  logic                         rd_en;
  logic [ffua_pkg::ID_BITS-1:0] rd_data;
  logic                         wr_en;
  logic [ffua_pkg::UNIT_W-1:0]  wr_addr;
  logic [ffua_pkg::ID_BITS-1:0] wr_data;
  logic                         rd_empty;
  logic                         found;
  logic                         scan_fail;
  logic                         finish_go;
  logic [ffua_pkg::CNT_W-1:0]   start_calc;
  ffua_pkg::stats_ctrl_t        stats_ctrl;
  ffua_pkg::stats_t             stats;

  always_comb begin
    if (mem_units == '0) begin
      n_units = ffua_pkg::CNT_W'(1);
    end else if (ffua_pkg::CNT_W'(mem_units) > MAX_CNT) begin
      n_units = MAX_CNT;
    end else begin
      n_units = ffua_pkg::CNT_W'(mem_units);
    end
  end

  assign in_size    = ffua_pkg::CNT_W'(request_size);
  assign in_bad     = (in_size == '0) || (in_size > n_units) || (owner_id == '0);
  assign rd_empty   = (rd_data == '0);
  assign found      = (state == ffua_pkg::ST_SCAN) && pend && rd_empty &&
                      ((run + ffua_pkg::CNT_W'(1)) >= req_size);
  assign scan_fail  = (state == ffua_pkg::ST_SCAN) && !found && !pend &&
                      (addr == n_units);
  assign finish_go  = !out_valid || out_ready;
  assign start_calc = ffua_pkg::CNT_W'(pend_addr) + ffua_pkg::CNT_W'(1) - req_size;

  always_comb begin
    state_next = state;
    case (state)
      ffua_pkg::ST_CLEAR: begin
        if (addr == MAX_CNT) begin
          state_next = ffua_pkg::ST_IDLE;
        end
      end
      ffua_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (kind == ffua_pkg::KIND_FREE) begin
            state_next = (owner_id == '0) ? ffua_pkg::ST_STATS : ffua_pkg::ST_FREE;
          end else begin
            state_next = in_bad ? ffua_pkg::ST_STATS : ffua_pkg::ST_SCAN;
          end
        end
      end
      ffua_pkg::ST_SCAN: begin
        if (found) begin
          state_next = ffua_pkg::ST_FILL;
        end else if (scan_fail) begin
          state_next = ffua_pkg::ST_STATS;
        end
      end
      ffua_pkg::ST_FILL: begin
        if (fill_cnt == req_size - ffua_pkg::CNT_W'(1)) begin
          state_next = ffua_pkg::ST_STATS;
        end
      end
      ffua_pkg::ST_FREE: begin
        if (addr == MAX_CNT && !pend) begin
          state_next = ffua_pkg::ST_STATS;
        end
      end
      ffua_pkg::ST_STATS: begin
        if (addr == n_units && !pend) begin
          state_next = ffua_pkg::ST_FINISH;
        end
      end
      ffua_pkg::ST_FINISH: begin
        if (finish_go) begin
          state_next = ffua_pkg::ST_IDLE;
        end
      end
      default: state_next = ffua_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = addr[ffua_pkg::UNIT_W-1:0];
    wr_data  = '0;
    case (state)
      ffua_pkg::ST_CLEAR: begin
        wr_en = (addr < MAX_CNT);
      end
      ffua_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ffua_pkg::ST_SCAN: begin
        rd_en = (addr < n_units) && !found;
      end
      ffua_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = start + fill_cnt[ffua_pkg::UNIT_W-1:0];
        wr_data = req_id;
      end
      ffua_pkg::ST_FREE: begin
        rd_en   = (addr < MAX_CNT);
        wr_en   = pend && (rd_data == req_id);
        wr_addr = pend_addr;
      end
      ffua_pkg::ST_STATS: begin
        rd_en = (addr < n_units);
      end
      default: begin
      end
    endcase
  end

  assign stats_ctrl.clear = (state_next == ffua_pkg::ST_STATS) && (state != ffua_pkg::ST_STATS);
  assign stats_ctrl.step  = (state == ffua_pkg::ST_STATS) && pend;
  assign stats_ctrl.empty = rd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffua_pkg::ST_CLEAR;
      addr      <= '0;
      pend      <= 1'b0;
      mem_units <= ffua_pkg::MEM_UNITS_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= rd_en;
      if (state != state_next) begin
        addr <= '0;
      end else if (rd_en || (state == ffua_pkg::ST_CLEAR)) begin
        addr <= addr + ffua_pkg::CNT_W'(1);
      end
      if (cfg_wr_en) begin
        mem_units <= cfg_wr_data;
      end
      if (state == ffua_pkg::ST_FINISH && finish_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= addr[ffua_pkg::UNIT_W-1:0];
    if (state == ffua_pkg::ST_IDLE) begin
      run      <= '0;
      fill_cnt <= '0;
      start    <= '0;
      req_id   <= owner_id;
      req_size <= in_size;
      if (kind == ffua_pkg::KIND_ALLOC && in_bad) begin
        status_q <= ffua_pkg::STATUS_BAD;
      end else begin
        status_q <= ffua_pkg::STATUS_DONE;
      end
    end
    if (state == ffua_pkg::ST_SCAN && pend) begin
      run <= rd_empty ? run + ffua_pkg::CNT_W'(1) : '0;
    end
    if (found) begin
      start <= start_calc[ffua_pkg::UNIT_W-1:0];
    end
    if (scan_fail) begin
      status_q <= ffua_pkg::STATUS_NO_HOLE;
    end
    if (state == ffua_pkg::ST_FILL) begin
      fill_cnt <= fill_cnt + ffua_pkg::CNT_W'(1);
    end
    if (state == ffua_pkg::ST_FINISH && finish_go) begin
      status        <= status_q;
      start_unit    <= ffua_pkg::START_W'(start);
      used_units    <= ffua_pkg::COUNT_W'(stats.used);
      largest_hole  <= ffua_pkg::COUNT_W'(stats.largest);
      smallest_hole <= ffua_pkg::COUNT_W'(stats.smallest);
    end
  end

  ffua_ram #(
    .DEPTH (ffua_pkg::MAX_UNITS),
    .WIDTH (ffua_pkg::ID_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr[ffua_pkg::UNIT_W-1:0]),
    .rd_data (rd_data)
  );

  ffua_hole_stats u_stats (
    .clk   (clk),
    .ctrl  (stats_ctrl),
    .stats (stats)
  );

endmodule
